// ----- hdl/ofsl_pkg.sv -----
// shared types and constants for the object file section loader
`timescale 1ns / 1ps

package ofsl_pkg;

  // parser phase within a record
  typedef enum logic [3:0] {
    PH_HDR_HI  = 4'd0,
    PH_HDR_LO  = 4'd1,
    PH_ADR_HI  = 4'd2,
    PH_ADR_LO  = 4'd3,
    PH_CNT_HI  = 4'd4,
    PH_CNT_LO  = 4'd5,
    PH_BODY_HI = 4'd6,
    PH_BODY_LO = 4'd7,
    PH_SKIP    = 4'd8,
    PH_IGNORE  = 4'd9
  } phase_e;

  // kind of record being parsed
  typedef enum logic [2:0] {
    RK_NONE  = 3'd0,
    RK_MEM   = 3'd1,
    RK_SYM   = 3'd2,
    RK_FNAME = 3'd3,
    RK_LINE  = 3'd4
  } rec_kind_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_DONE_OK = 2'd1,
    KIND_BAD_HDR = 2'd2
  } res_kind_e;

  // record header words
  localparam logic [15:0] HDR_DATA  = 16'hDADA;
  localparam logic [15:0] HDR_CODE  = 16'hCADE;
  localparam logic [15:0] HDR_SYM   = 16'hC3B7;
  localparam logic [15:0] HDR_FNAME = 16'hF17E;
  localparam logic [15:0] HDR_LINE  = 16'h715E;

  // bytes skipped by a line-number record
  localparam logic [15:0] LINE_SKIP_BYTES = 16'd6;

  // result queue depth
  localparam int unsigned RES_DEPTH = 4;

  // parser to result queue push control
  typedef struct packed {
    logic [1:0] push_cnt;
  } push_ctl_t;

endpackage

// ----- hdl/ofsl_parser.sv -----
// input byte register and record state machine, emits up to two results per byte
`timescale 1ns / 1ps

module ofsl_parser #(
  parameter int unsigned ADDRESS_BITS = 16,
  parameter int unsigned RES_W        = 2 + ADDRESS_BITS + 16 + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               end_of_file_i,
  input  logic               room_i,
  output ofsl_pkg::push_ctl_t push_o,
  output logic [RES_W-1:0]   res0_o,
  output logic [RES_W-1:0]   res1_o
);

  // input register
  logic       vld_q;
  logic [7:0] byte_q;
  logic       eof_q;
  logic       proc;

  // record state
  ofsl_pkg::phase_e    phase_q, phase_d;
  ofsl_pkg::rec_kind_e rk_q, rk_d;
  logic [7:0]              hi_q, hi_d;
  logic [ADDRESS_BITS-1:0] addr_q, addr_d;
  logic [ADDRESS_BITS-1:0] idx_q, idx_d;
  logic [15:0]             rem_q, rem_d;
  logic                    failed_q, failed_d;

  logic [15:0]             word;
  logic                    wr;
  logic                    fail_nx;
  logic [ADDRESS_BITS-1:0] wr_addr;
  logic [RES_W-1:0]        wr_res;
  logic [RES_W-1:0]        done_res;
  ofsl_pkg::res_kind_e     done_kind;

  assign proc       = vld_q && room_i;
  assign in_ready_o = !vld_q || proc;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
      eof_q  <= end_of_file_i;
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ofsl_pkg::PH_HDR_HI;
      rk_q     <= ofsl_pkg::RK_NONE;
      hi_q     <= '0;
      addr_q   <= '0;
      idx_q    <= '0;
      rem_q    <= '0;
      failed_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      rk_q     <= rk_d;
      hi_q     <= hi_d;
      addr_q   <= addr_d;
      idx_q    <= idx_d;
      rem_q    <= rem_d;
      failed_q <= failed_d;
    end
  end

  assign word    = {hi_q, byte_q};
  assign wr_addr = addr_q + idx_q;

  // next state and write detection
  always_comb begin
    phase_d  = phase_q;
    rk_d     = rk_q;
    hi_d     = hi_q;
    addr_d   = addr_q;
    idx_d    = idx_q;
    rem_d    = rem_q;
    failed_d = failed_q;
    fail_nx  = failed_q;
    wr       = 1'b0;
    if (proc) begin
      case (phase_q)
        ofsl_pkg::PH_HDR_HI: begin
          hi_d    = byte_q;
          phase_d = ofsl_pkg::PH_HDR_LO;
        end
        ofsl_pkg::PH_ADR_HI: begin
          hi_d    = byte_q;
          phase_d = ofsl_pkg::PH_ADR_LO;
        end
        ofsl_pkg::PH_CNT_HI: begin
          hi_d    = byte_q;
          phase_d = ofsl_pkg::PH_CNT_LO;
        end
        ofsl_pkg::PH_BODY_HI: begin
          hi_d    = byte_q;
          phase_d = ofsl_pkg::PH_BODY_LO;
        end
        ofsl_pkg::PH_HDR_LO: begin
          if (word == ofsl_pkg::HDR_DATA || word == ofsl_pkg::HDR_CODE) begin
            rk_d    = ofsl_pkg::RK_MEM;
            phase_d = ofsl_pkg::PH_ADR_HI;
          end else if (word == ofsl_pkg::HDR_SYM) begin
            rk_d    = ofsl_pkg::RK_SYM;
            phase_d = ofsl_pkg::PH_ADR_HI;
          end else if (word == ofsl_pkg::HDR_FNAME) begin
            rk_d    = ofsl_pkg::RK_FNAME;
            phase_d = ofsl_pkg::PH_CNT_HI;
          end else if (word == ofsl_pkg::HDR_LINE) begin
            rk_d    = ofsl_pkg::RK_LINE;
            rem_d   = ofsl_pkg::LINE_SKIP_BYTES;
            phase_d = ofsl_pkg::PH_SKIP;
          end else begin
            rk_d     = ofsl_pkg::RK_NONE;
            failed_d = 1'b1;
            phase_d  = ofsl_pkg::PH_IGNORE;
          end
        end
        ofsl_pkg::PH_ADR_LO: begin
          addr_d  = word[ADDRESS_BITS-1:0];
          phase_d = ofsl_pkg::PH_CNT_HI;
        end
        ofsl_pkg::PH_CNT_LO: begin
          rem_d = word;
          idx_d = '0;
          if (word == 16'd0) begin
            phase_d = ofsl_pkg::PH_HDR_HI;
          end else if (rk_q == ofsl_pkg::RK_MEM) begin
            phase_d = ofsl_pkg::PH_BODY_HI;
          end else begin
            phase_d = ofsl_pkg::PH_SKIP;
          end
        end
        ofsl_pkg::PH_BODY_LO: begin
          wr      = 1'b1;
          idx_d   = idx_q + 1'b1;
          rem_d   = rem_q - 16'd1;
          phase_d = (rem_d == 16'd0) ? ofsl_pkg::PH_HDR_HI : ofsl_pkg::PH_BODY_HI;
        end
        ofsl_pkg::PH_SKIP: begin
          rem_d = rem_q - 16'd1;
          if (rem_d == 16'd0) begin
            phase_d = ofsl_pkg::PH_HDR_HI;
          end
        end
        ofsl_pkg::PH_IGNORE: begin
          phase_d = ofsl_pkg::PH_IGNORE;
        end
        default: begin
          phase_d = ofsl_pkg::PH_HDR_HI;
        end
      endcase
      // failure as it stands after this byte, a bad header on the final byte included
      fail_nx = failed_d;
      // final byte returns everything to reset
      if (eof_q) begin
        phase_d  = ofsl_pkg::PH_HDR_HI;
        rk_d     = ofsl_pkg::RK_NONE;
        hi_d     = '0;
        addr_d   = '0;
        idx_d    = '0;
        rem_d    = '0;
        failed_d = 1'b0;
      end
    end
  end

  // result packing: kind, address, data, last
  assign done_kind = fail_nx ? ofsl_pkg::KIND_BAD_HDR : ofsl_pkg::KIND_DONE_OK;
  assign wr_res   = {ofsl_pkg::KIND_WRITE, wr_addr, word, !eof_q};
  assign done_res = {done_kind, {ADDRESS_BITS{1'b0}}, 16'd0, 1'b1};

  always_comb begin
    res0_o          = wr ? wr_res : done_res;
    res1_o          = done_res;
    push_o.push_cnt = 2'd0;
    if (proc) begin
      push_o.push_cnt = {1'b0, wr} + {1'b0, eof_q};
    end
  end

  // two results only come from the final byte
  a_two_only_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push_cnt == 2'd2 |-> eof_q)
    else $error("two results pushed for a non-final byte");

  // final byte leaves the parser at a fresh file
  a_eof_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && eof_q |=> phase_q == ofsl_pkg::PH_HDR_HI && !failed_q)
    else $error("state not cleared after final byte");

  // ignoring bytes only after a bad header
  a_ignore_failed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == ofsl_pkg::PH_IGNORE |-> failed_q)
    else $error("ignore phase without failure flag");

  // a stalled byte holds the parser state
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !room_i |=> $stable(phase_q) && $stable(rem_q))
    else $error("state moved while byte was stalled");

endmodule

// ----- hdl/ofsl_result_fifo.sv -----
// small result queue, up to two pushes and one pop per cycle
`timescale 1ns / 1ps

module ofsl_result_fifo #(
  parameter int unsigned WIDTH = 35,
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ofsl_pkg::push_ctl_t push_i,
  input  logic [WIDTH-1:0]    din0_i,
  input  logic [WIDTH-1:0]    din1_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [WIDTH-1:0]    dout_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d, wnext;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wnext       = ptr_inc(wptr_q);
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign dout_o      = mem_q[rptr_q];
  assign room_o      = cnt_q <= CNT_W'(DEPTH - 2);

  // pointer and count update
  always_comb begin
    wptr_d = wptr_q;
    case (push_i.push_cnt)
      2'd1:    wptr_d = wnext;
      2'd2:    wptr_d = ptr_inc(wnext);
      default: wptr_d = wptr_q;
    endcase
    rptr_d = pop ? ptr_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q + CNT_W'(push_i.push_cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.push_cnt != 2'd0) begin
      mem_q[wptr_q] <= din0_i;
    end
    if (push_i.push_cnt == 2'd2) begin
      mem_q[wnext] <= din1_i;
    end
  end

  // never overfilled
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("result queue overflow");

endmodule

// ----- hdl/object_file_section_loader_top.sv -----
// top level of the object file section loader
`timescale 1ns / 1ps

// Object file section loader: takes one object-file byte per transaction and
// emits memory-write and load-done results. A byte is accepted every cycle while
// the four-entry result queue has two free slots; the result of a byte passes
// through the input register, then the queue entry, before it is offered.
// Only the final byte of a file can yield two results (a last body write and
// the done result), which the queue absorbs without slowing the stream when the
// output side takes one result per cycle.

module object_file_section_loader_top #(
  parameter int unsigned ADDRESS_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              in_byte_i,
  input  logic                    end_of_file_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              kind_o,
  output logic [ADDRESS_BITS-1:0] write_address_o,
  output logic [15:0]             write_data_o,
  output logic                    last_of_run_o
);

  localparam int unsigned RES_W = 2 + ADDRESS_BITS + 16 + 1;

  ofsl_pkg::push_ctl_t push;
  logic [RES_W-1:0]    res0, res1, dout;
  logic                room;

  // byte parser
  ofsl_parser #(
    .ADDRESS_BITS(ADDRESS_BITS),
    .RES_W       (RES_W)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .end_of_file_i(end_of_file_i),
    .room_i       (room),
    .push_o       (push),
    .res0_o       (res0),
    .res1_o       (res1)
  );

  // result queue
  ofsl_result_fifo #(
    .WIDTH(RES_W),
    .DEPTH(ofsl_pkg::RES_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .din0_i     (res0),
    .din1_i     (res1),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .dout_o     (dout)
  );

  // unpack result fields
  assign kind_o          = dout[RES_W-1 -: 2];
  assign write_address_o = dout[17 +: ADDRESS_BITS];
  assign write_data_o    = dout[16:1];
  assign last_of_run_o   = dout[0];

endmodule

// ----- tb/object_file_section_loader_top_test.sv -----
// self-checking testbench for the object file section loader
`timescale 1ns / 1ps

module object_file_section_loader_top_test;

  localparam int unsigned ADDR_BITS = 16;
  localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDR_BITS) - 1);
  localparam int RANDOM_BYTES = 1550;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int NUM_DIRECTED = 36;

  // one loader result as seen on the output channel
  typedef struct packed {
    ofsl_pkg::res_kind_e kind;
    logic [15:0]         addr;
    logic [15:0]         data;
    logic                is_last;
  } ldr_res_t;

  // one directed stimulus row, with typed results where obvious
  typedef struct packed {
    logic [7:0]  in_byte;
    logic        eof;
    logic        typed;
    logic [1:0]  num_res;
    ldr_res_t    res0;
    ldr_res_t    res1;
  } dir_row_t;

  localparam ldr_res_t NO_RES  = '{kind: ofsl_pkg::KIND_WRITE, addr: 16'h0, data: 16'h0,
                                   is_last: 1'b0};
  localparam ldr_res_t DONE_OK = '{kind: ofsl_pkg::KIND_DONE_OK, addr: 16'h0, data: 16'h0,
                                   is_last: 1'b1};
  localparam ldr_res_t DONE_BAD = '{kind: ofsl_pkg::KIND_BAD_HDR, addr: 16'h0, data: 16'h0,
                                    is_last: 1'b1};

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           in_byte_i = 8'h00;
  logic                 end_of_file_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [1:0]           kind_o;
  logic [ADDR_BITS-1:0] write_address_o;
  logic [15:0]          write_data_o;
  logic                 last_of_run_o;

  // predictor state
  ofsl_pkg::phase_e    ld_phase = ofsl_pkg::PH_HDR_HI;
  logic [7:0]          ld_hi = 8'h00;
  ofsl_pkg::rec_kind_e ld_kind = ofsl_pkg::RK_NONE;
  logic [15:0]         ld_addr = 16'h0;
  logic [15:0]         ld_left = 16'h0;
  logic [15:0]         ld_idx = 16'h0;
  logic                ld_failed = 1'b0;

  ldr_res_t   load_results_q[$];
  logic [7:0] file_q[$];
  dir_row_t   dir_tbl [NUM_DIRECTED];
  int         errors = 0;
  int         cycle_cnt = 0;
  int         burst_left = 0;
  int         sent_bytes = 0;
  logic       hold_go = 1'b0;

  object_file_section_loader_top #(
    .ADDRESS_BITS(ADDR_BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .end_of_file_i  (end_of_file_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .write_address_o(write_address_o),
    .write_data_o   (write_data_o),
    .last_of_run_o  (last_of_run_o)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // loader prediction: advance the record parser by one byte
  function automatic int step_loader(input logic [7:0] b, input logic eof,
                                     output ldr_res_t r0, output ldr_res_t r1);
    logic [15:0] word;
    int n;
    word = {ld_hi, b};
    n = 0;
    r0 = NO_RES;
    r1 = NO_RES;
    case (ld_phase)
      ofsl_pkg::PH_HDR_HI, ofsl_pkg::PH_ADR_HI, ofsl_pkg::PH_CNT_HI,
      ofsl_pkg::PH_BODY_HI: begin
        ld_hi = b;
        ld_phase = ofsl_pkg::phase_e'(ld_phase + 4'd1);
      end
      ofsl_pkg::PH_HDR_LO: begin
        if (word == ofsl_pkg::HDR_DATA || word == ofsl_pkg::HDR_CODE) begin
          ld_kind = ofsl_pkg::RK_MEM;
          ld_phase = ofsl_pkg::PH_ADR_HI;
        end else if (word == ofsl_pkg::HDR_SYM) begin
          ld_kind = ofsl_pkg::RK_SYM;
          ld_phase = ofsl_pkg::PH_ADR_HI;
        end else if (word == ofsl_pkg::HDR_FNAME) begin
          ld_kind = ofsl_pkg::RK_FNAME;
          ld_phase = ofsl_pkg::PH_CNT_HI;
        end else if (word == ofsl_pkg::HDR_LINE) begin
          ld_kind = ofsl_pkg::RK_LINE;
          ld_left = ofsl_pkg::LINE_SKIP_BYTES;
          ld_phase = ofsl_pkg::PH_SKIP;
        end else begin
          ld_kind = ofsl_pkg::RK_NONE;
          ld_failed = 1'b1;
          ld_phase = ofsl_pkg::PH_IGNORE;
        end
      end
      ofsl_pkg::PH_ADR_LO: begin
        ld_addr = word;
        ld_phase = ofsl_pkg::PH_CNT_HI;
      end
      ofsl_pkg::PH_CNT_LO: begin
        ld_left = word;
        ld_idx = 16'h0;
        if (word == 16'h0) ld_phase = ofsl_pkg::PH_HDR_HI;
        else if (ld_kind == ofsl_pkg::RK_MEM) ld_phase = ofsl_pkg::PH_BODY_HI;
        else ld_phase = ofsl_pkg::PH_SKIP;
      end
      ofsl_pkg::PH_BODY_LO: begin
        r0 = '{kind: ofsl_pkg::KIND_WRITE, addr: (ld_addr + ld_idx) & ADDR_MASK,
               data: word, is_last: 1'b1};
        n = 1;
        ld_idx = ld_idx + 16'd1;
        ld_left = ld_left - 16'd1;
        ld_phase = (ld_left == 16'h0) ? ofsl_pkg::PH_HDR_HI : ofsl_pkg::PH_BODY_HI;
      end
      ofsl_pkg::PH_SKIP: begin
        ld_left = ld_left - 16'd1;
        if (ld_left == 16'h0) ld_phase = ofsl_pkg::PH_HDR_HI;
      end
      ofsl_pkg::PH_IGNORE: begin
      end
      default: ld_phase = ofsl_pkg::PH_HDR_HI;
    endcase
    // end of file closes the load and clears the parser
    if (eof) begin
      if (n == 1) begin
        r0.is_last = 1'b0;
        r1 = ld_failed ? DONE_BAD : DONE_OK;
      end else begin
        r0 = ld_failed ? DONE_BAD : DONE_OK;
      end
      n++;
      ld_phase = ofsl_pkg::PH_HDR_HI;
      ld_hi = 8'h00;
      ld_kind = ofsl_pkg::RK_NONE;
      ld_addr = 16'h0;
      ld_left = 16'h0;
      ld_idx = 16'h0;
      ld_failed = 1'b0;
    end
    return n;
  endfunction

  // drive one byte transaction in bursts, then record what it should produce
  task automatic offer_byte(input logic [7:0] b, input logic eof, input logic typed,
                            input int tn, input ldr_res_t t0, input ldr_res_t t1);
    int gap;
    int n;
    ldr_res_t p0;
    ldr_res_t p1;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 8);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    end_of_file_i <= eof;
    burst_left--;
    do @(posedge clk_i); while (!in_ready_o);
    n = step_loader(b, eof, p0, p1);
    if (typed) begin
      n = tn;
      p0 = t0;
      p1 = t1;
    end
    if (n > 0) load_results_q.push_back(p0);
    if (n > 1) load_results_q.push_back(p1);
    sent_bytes++;
  endtask

  // stop offering until every expected result has come, then let the pipe settle
  task automatic drain_results;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (load_results_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic void push_word(input logic [15:0] w);
    file_q.push_back(w[15:8]);
    file_q.push_back(w[7:0]);
  endfunction

  // record counts: mostly short, some empty, a few longer
  function automatic logic [15:0] pick_count;
    if ($urandom_range(0, 9) == 0) return 16'd0;
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(10, 24));
    return 16'($urandom_range(1, 5));
  endfunction

  // build one random object file: mostly well-formed records, some noise and cuts
  task automatic build_file;
    int nrec;
    int sel;
    int cut;
    logic [15:0] cnt;
    file_q.delete();
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom));
      return;
    end
    nrec = $urandom_range(1, 5);
    for (int i = 0; i < nrec; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        push_word($urandom_range(0, 1) ? ofsl_pkg::HDR_DATA : ofsl_pkg::HDR_CODE);
        push_word(($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 3))
                                               : 16'($urandom));
        cnt = pick_count();
        push_word(cnt);
        repeat (cnt) push_word(16'($urandom));
      end else if (sel < 55) begin
        push_word(ofsl_pkg::HDR_SYM);
        push_word(16'($urandom));
        cnt = pick_count();
        push_word(cnt);
        repeat (cnt) file_q.push_back(8'($urandom));
      end else if (sel < 70) begin
        push_word(ofsl_pkg::HDR_FNAME);
        cnt = pick_count();
        push_word(cnt);
        repeat (cnt) file_q.push_back(8'($urandom));
      end else if (sel < 88) begin
        push_word(ofsl_pkg::HDR_LINE);
        repeat (6) file_q.push_back(8'($urandom));
      end else begin
        push_word(16'($urandom));
        repeat ($urandom_range(0, 6)) file_q.push_back(8'($urandom));
      end
    end
    // truncated file
    if ($urandom_range(0, 6) == 0 && file_q.size() > 1) begin
      cut = $urandom_range(1, file_q.size() - 1);
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
  endtask

  // receiver: one long hold-off, otherwise rotating stall patterns
  initial begin
    logic [15:0] rdy_pat;
    int pat_left;
    int hold_left;
    logic hold_done;
    rdy_pat = 16'hFFFF;
    pat_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          case ($urandom_range(0, 3))
            0: rdy_pat = 16'hFFFF;
            1: rdy_pat = 16'($urandom);
            2: rdy_pat = 16'($urandom) | 16'($urandom);
            default: rdy_pat = 16'($urandom) & 16'($urandom);
          endcase
          if (rdy_pat == 16'h0) rdy_pat = 16'h0001;
          pat_left = $urandom_range(16, 96);
        end
        out_ready_i <= rdy_pat[0];
        rdy_pat = {rdy_pat[0], rdy_pat[15:1]};
        pat_left--;
      end
    end
  end

  // output check against the oldest expected result
  always @(posedge clk_i) begin : check_out
    ldr_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (load_results_q.size() == 0) begin
        $display("%0t unexpected result: kind %0d addr %h data %h last %b",
                 $time, kind_o, write_address_o, write_data_o, last_of_run_o);
        errors++;
      end else begin
        want = load_results_q.pop_front();
        if (kind_o !== want.kind || write_address_o !== want.addr[ADDR_BITS-1:0] ||
            write_data_o !== want.data || last_of_run_o !== want.is_last) begin
          $display({"%0t mismatch: expected kind %0d addr %h data %h last %b,",
                    " got kind %0d addr %h data %h last %b"},
                   $time, want.kind, want.addr, want.data, want.is_last,
                   kind_o, write_address_o, write_data_o, last_of_run_o);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int file_cnt;
    // lone end-of-file byte right after reset
    dir_tbl[0]  = '{8'hFF, 1'b1, 1'b1, 2'd1, DONE_OK, NO_RES};
    // data record at the top of memory, two words, address wraps
    dir_tbl[1]  = '{8'hDA, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[2]  = '{8'hDA, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[3]  = '{8'hFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[4]  = '{8'hFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[5]  = '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[6]  = '{8'h02, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[7]  = '{8'h12, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[8]  = '{8'h34, 1'b0, 1'b1, 2'd1,
                    '{kind: ofsl_pkg::KIND_WRITE, addr: 16'hFFFF, data: 16'h1234,
                      is_last: 1'b1}, NO_RES};
    dir_tbl[9]  = '{8'hAB, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[10] = '{8'hCD, 1'b0, 1'b1, 2'd1,
                    '{kind: ofsl_pkg::KIND_WRITE, addr: 16'h0000, data: 16'hABCD,
                      is_last: 1'b1}, NO_RES};
    // line-number record, six skipped bytes
    dir_tbl[11] = '{8'h71, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[12] = '{8'h5E, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    for (int i = 13; i < 19; i++) dir_tbl[i] = '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    // file-name record with zero count
    dir_tbl[19] = '{8'hF1, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[20] = '{8'h7E, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[21] = '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[22] = '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    // code record cut short: last byte completes a word, then done
    dir_tbl[23] = '{8'hCA, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[24] = '{8'hDE, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[25] = '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[26] = '{8'h10, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[27] = '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[28] = '{8'h05, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[29] = '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[30] = '{8'hFF, 1'b1, 1'b1, 2'd2,
                    '{kind: ofsl_pkg::KIND_WRITE, addr: 16'h0010, data: 16'h00FF,
                      is_last: 1'b0}, DONE_OK};
    // unknown header, rest ignored until end of file
    dir_tbl[31] = '{8'h12, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[32] = '{8'h34, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[33] = '{8'h00, 1'b1, 1'b1, 2'd1, DONE_BAD, NO_RES};
    // unknown header completed by the final byte itself
    dir_tbl[34] = '{8'h12, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
    dir_tbl[35] = '{8'h34, 1'b1, 1'b1, 2'd1, DONE_BAD, NO_RES};

    // reset
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      offer_byte(dir_tbl[i].in_byte, dir_tbl[i].eof, dir_tbl[i].typed,
                 int'(dir_tbl[i].num_res), dir_tbl[i].res0, dir_tbl[i].res1);
    end
    drain_results();

    // random files; receiver holds off early so the block backs up
    hold_go = 1'b1;
    sent_bytes = 0;
    file_cnt = 0;
    while (sent_bytes < RANDOM_BYTES) begin
      build_file();
      for (int i = 0; i < file_q.size(); i++) begin
        offer_byte(file_q[i], (i == file_q.size() - 1), 1'b0, 0, NO_RES, NO_RES);
      end
      file_cnt++;
      if (file_cnt == 30) drain_results();
    end

    // final drain and verdict
    drain_results();
    if (errors == 0 && load_results_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
